// ===== src/stbs_pkg.sv =====
// Shared definitions for the sort-then-binary-search core.
// Holds default sizes and the command and status bundles between the
// controller and the datapath. Depends on nothing.
`default_nettype none
package stbs_pkg;

   // Default sizes of the element store.
   localparam int CAPACITY    = 256;
   localparam int VALUE_WIDTH = 32;

   // Request kinds carried in tuser.
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // Commands from the controller, one per step of work.
   typedef struct packed {
      logic load;      // accept a load word
      logic search;    // accept a search word
      logic rd_first;  // read element 0 to start a pass
      logic take_first;// capture element 0 as the running maximum
      logic rd_next;   // read element j
      logic compare;   // compare element j, write back slot j-1
      logic pass_end;  // write the running maximum at the pass end
      logic probe;     // issue a search probe at the midpoint
      logic probe_cmp; // compare the probed element with the key
      logic rsp_sort;  // post the load-finished answer
      logic rsp_search;// post the search answer
   } cmd_type;

   // Status back to the controller.
   typedef struct packed {
      logic short_array; // finished array has fewer than two elements
      logic j_at_end;    // element j is the last of this pass
      logic stop_sort;   // pass made no swap, or only one pair is left
      logic range_empty; // search range low > high
      logic hit;         // probed element equals the key
      logic slot_free;   // output register can take a word
   } status_type;

endpackage
`default_nettype wire

// ===== src/stbs_controller.sv =====
// Controller state machine of the sort-then-binary-search core.
// Sequences loads, the bubble-sort passes and the search probes.
// Depends on stbs_pkg.
`default_nettype none
module stbs_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic                req_kind,
   input  wire logic                req_last,
   input  wire stbs_pkg::status_type status,
   output stbs_pkg::cmd_type        cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_RD_FIRST  = 4'd1;
   localparam logic [3:0] ST_TAKE      = 4'd2;
   localparam logic [3:0] ST_RD_NEXT   = 4'd3;
   localparam logic [3:0] ST_COMPARE   = 4'd4;
   localparam logic [3:0] ST_PASS_END  = 4'd5;
   localparam logic [3:0] ST_PROBE     = 4'd6;
   localparam logic [3:0] ST_PROBE_CMP = 4'd7;
   localparam logic [3:0] ST_RSP_SORT  = 4'd8;
   localparam logic [3:0] ST_RSP_SRCH  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and the command of the current step.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == stbs_pkg::REQ_SEARCH) begin
                  cmd.search = 1'b1;
                  state_in   = ST_PROBE;
               end else begin
                  cmd.load = 1'b1;
                  if (req_last) begin
                     state_in = status.short_array ? ST_RSP_SORT : ST_RD_FIRST;
                  end
               end
            end
         end
         ST_RD_FIRST: begin
            cmd.rd_first = 1'b1;
            state_in     = ST_TAKE;
         end
         ST_TAKE: begin
            cmd.take_first = 1'b1;
            state_in       = ST_RD_NEXT;
         end
         ST_RD_NEXT: begin
            cmd.rd_next = 1'b1;
            state_in    = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = status.j_at_end ? ST_PASS_END : ST_RD_NEXT;
         end
         ST_PASS_END: begin
            cmd.pass_end = 1'b1;
            state_in     = status.stop_sort ? ST_RSP_SORT : ST_RD_FIRST;
         end
         ST_PROBE: begin
            if (status.range_empty) begin
               state_in = ST_RSP_SRCH;
            end else begin
               cmd.probe = 1'b1;
               state_in  = ST_PROBE_CMP;
            end
         end
         ST_PROBE_CMP: begin
            cmd.probe_cmp = 1'b1;
            state_in      = status.hit ? ST_RSP_SRCH : ST_PROBE;
         end
         ST_RSP_SORT: begin
            if (status.slot_free) begin
               cmd.rsp_sort = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RSP_SRCH: begin
            if (status.slot_free) begin
               cmd.rsp_search = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/stbs_datapath.sv =====
// Datapath of the sort-then-binary-search core: element memory, pass and
// search registers, compare logic and the output register.
// Depends on stbs_pkg.
`default_nettype none
module stbs_datapath #(
   parameter int CAPACITY    = stbs_pkg::CAPACITY,
   parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [31:0]         req_value,
   input  wire logic                req_last,
   input  wire stbs_pkg::cmd_type   cmd,
   output stbs_pkg::status_type     status,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic                     rsp_kind,
   output logic                     rsp_already_sorted,
   output logic                     rsp_overflowed,
   output logic                     rsp_found,
   output logic [7:0]               rsp_position
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = IW + 1;
   localparam int SW = IW + 2;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   // Element memory, one write and one registered read per cycle.
   logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] rd_ff;
   logic        [IW-1:0]          rd_addr;
   logic                          rd_en;
   logic        [IW-1:0]          wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;
   logic                          wr_en;

   logic        [CW-1:0]          count_ff, lp_ff;
   logic                          ovf_ff;
   logic        [IW-1:0]          end_ff, j_ff;
   logic signed [VALUE_WIDTH-1:0] cur_ff, key_ff;
   logic                          swapped_ff, first_ff, sorted_ff;
   logic signed [SW-1:0]          lo_ff, hi_ff;
   logic        [IW-1:0]          mid_ff;
   logic                          found_ff;

   logic signed [63:0]            value_ext;
   logic signed [VALUE_WIDTH-1:0] value_key;
   logic        [CW-1:0]          lp_next;
   logic                          lp_room;
   logic signed [SW-1:0]          mid_s;
   logic                          smaller;

   // Sign-extend the request and keep the low VALUE_WIDTH bits.
   assign value_ext = 64'(signed'(req_value));
   assign value_key = value_ext[VALUE_WIDTH-1:0];

   assign lp_room = (lp_ff < CAP_C);
   assign lp_next = lp_room ? (lp_ff + CW'(1)) : lp_ff;

   assign mid_s   = lo_ff + ((hi_ff - lo_ff) >>> 1);
   assign smaller = (rd_ff < cur_ff);

   // Memory port selection.
   always_comb begin
      rd_en   = cmd.rd_first | cmd.rd_next | cmd.probe;
      rd_addr = cmd.probe ? mid_s[IW-1:0] : (cmd.rd_first ? '0 : j_ff);
      wr_en   = (cmd.load & lp_room) | cmd.compare | cmd.pass_end;
      wr_addr = lp_ff[IW-1:0];
      wr_data = value_key;
      if (cmd.compare) begin
         wr_addr = j_ff - IW'(1);
         wr_data = smaller ? rd_ff : cur_ff;
      end else if (cmd.pass_end) begin
         wr_addr = end_ff;
         wr_data = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Status to the controller.
   always_comb begin
      status.short_array = (lp_next < CW'(2));
      status.j_at_end    = (j_ff == end_ff);
      status.stop_sort   = !swapped_ff || (end_ff == IW'(1));
      status.range_empty = (lo_ff > hi_ff);
      status.hit         = (rd_ff == key_ff);
      status.slot_free   = !rsp_tvalid || rsp_tready;
   end

   // Load bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         lp_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (lp_ff == '0) begin
            count_ff <= '0;
         end
         if (req_last) begin
            count_ff <= lp_next;
            lp_ff    <= '0;
         end else begin
            lp_ff <= lp_next;
         end
         if (!lp_room) begin
            ovf_ff <= 1'b1;
         end else if (lp_ff == '0) begin
            ovf_ff <= 1'b0;
         end
      end
   end

   // Bubble-sort passes that carry the running maximum in a register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         end_ff    <= IW'(lp_next - CW'(1));
         first_ff  <= 1'b1;
         sorted_ff <= 1'b1;
      end
      if (cmd.rd_first) begin
         swapped_ff <= 1'b0;
      end
      if (cmd.take_first) begin
         cur_ff <= rd_ff;
         j_ff   <= IW'(1);
      end
      if (cmd.compare) begin
         if (smaller) begin
            swapped_ff <= 1'b1;
            if (first_ff) begin
               sorted_ff <= 1'b0;
            end
         end else begin
            cur_ff <= rd_ff;
         end
         j_ff <= j_ff + IW'(1);
      end
      if (cmd.pass_end) begin
         first_ff <= 1'b0;
         end_ff   <= end_ff - IW'(1);
      end
   end

   // Binary search range and probe.
   always_ff @(posedge clock) begin
      if (cmd.search) begin
         key_ff   <= value_key;
         lo_ff    <= '0;
         hi_ff    <= SW'(count_ff) - SW'(1);
         found_ff <= 1'b0;
      end
      if (cmd.probe) begin
         mid_ff <= mid_s[IW-1:0];
      end
      if (cmd.probe_cmp) begin
         if (rd_ff == key_ff) begin
            found_ff <= 1'b1;
         end else if (rd_ff < key_ff) begin
            lo_ff <= SW'(mid_ff) + SW'(1);
         end else begin
            hi_ff <= SW'(mid_ff) - SW'(1);
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (cmd.rsp_sort || cmd.rsp_search) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
      if (cmd.rsp_sort) begin
         rsp_kind           <= 1'b0;
         rsp_already_sorted <= sorted_ff;
         rsp_overflowed     <= ovf_ff;
         rsp_found          <= 1'b0;
         rsp_position       <= '0;
      end
      if (cmd.rsp_search) begin
         rsp_kind           <= 1'b1;
         rsp_already_sorted <= 1'b0;
         rsp_overflowed     <= ovf_ff;
         rsp_found          <= found_ff;
         rsp_position       <= found_ff ? 8'(mid_ff) : 8'd0;
      end
   end

endmodule
`default_nettype wire

// ===== src/sort_then_binary_search_core.sv =====
// Top level of the sort-then-binary-search core.
// Joins stbs_controller and stbs_datapath. Depends on stbs_pkg.
//
// Load words (tuser 0) write one signed fixed-point element each; the one
// with tlast finishes the array, which is then sorted in place by bubble
// passes on the element memory, and one word reports whether it was
// already ascending. Each element of a pass is read from and written back
// to the memory. A search word (tuser 1) runs binary-search probes, each
// reading the midpoint element and comparing it with the key. Loads
// beyond the capacity are dropped and flagged. The output register lets
// the next word be taken while an answer waits.
`default_nettype none
module sort_then_binary_search_core #(
   parameter int CAPACITY    = stbs_pkg::CAPACITY,
   parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [31:0] value
   input  wire logic        req_tuser,  // [0] req_type
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [0] already_sorted, [1] overflowed,
                                        // [2] found, [10:3] position, zeros
   output logic             rsp_tuser   // [0] kind
);

   stbs_pkg::cmd_type    cmd;
   stbs_pkg::status_type status;
   logic                 already_sorted, overflowed, found;
   logic [7:0]           position;

   stbs_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_last   (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   stbs_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_value          (req_tdata),
      .req_last           (req_tlast),
      .cmd                (cmd),
      .status             (status),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_kind           (rsp_tuser),
      .rsp_already_sorted (already_sorted),
      .rsp_overflowed     (overflowed),
      .rsp_found          (found),
      .rsp_position       (position)
   );

   // Pack the answer word.
   assign rsp_tdata = {5'd0, position, found, overflowed, already_sorted};

endmodule
`default_nettype wire
